// File: src/ftms_pkg.sv
// shared types, constants and helpers of the fuzzy text match scorer
package ftms_pkg;

  localparam int CHAR_W    = 8;
  localparam int SCORE_W   = 21;
  localparam int KIND_W    = 3;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_LEN_W = 5;
  localparam int WORD_CNT  = 4;
  localparam int CFG_CHARS = 16;

  typedef logic [CHAR_W-1:0] char_t;

  // one accepted text word after folding
  typedef struct packed {
    char_t text_char;
    logic  char_present;
    logic  last;
  } item_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 3'd0,
    KIND_PREFIX  = 3'd1,
    KIND_SUBSTR  = 3'd2,
    KIND_SUBSEQ  = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD0  = 3'd1,
    REG_PATTERN_WORD1  = 3'd2,
    REG_PATTERN_WORD2  = 3'd3,
    REG_PATTERN_WORD3  = 3'd4
  } cfg_reg_t;

  // ascii lower-case fold, only A..Z change
  function automatic char_t fold(input char_t ch);
    char_t res;
    res = ch;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      res = ch + 8'h20;
    end
    return res;
  endfunction

endpackage

// File: src/ftms_ifs.sv
// valid/ready channel interfaces for text words and scores
interface ftms_in_if;
  logic            valid;
  logic            ready;
  ftms_pkg::char_t text_char;
  logic            char_present;
  logic            last;

  modport source (output valid, text_char, char_present, last, input ready);
  modport sink   (input valid, text_char, char_present, last, output ready);
endinterface

interface ftms_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ftms_pkg::SCORE_W-1:0]    score;
  logic [ftms_pkg::KIND_W-1:0]            match_kind;
  logic                                   length_saturated;

  modport source (output valid, score, match_kind, length_saturated, input ready);
  modport sink   (input valid, score, match_kind, length_saturated, output ready);
endinterface

// File: src/ftms_front.sv
// input side: accepts text words, folds case and drops empty non-final words
module ftms_front (
  ftms_in_if.sink          in_ch,
  input  logic             full,
  output logic             push,
  output ftms_pkg::item_t  push_item
);

  assign in_ch.ready = !full;

  // a word with no character and no last flag carries nothing
  assign push = in_ch.valid && !full && (in_ch.char_present || in_ch.last);

  always_comb begin
    push_item.text_char    = ftms_pkg::fold(in_ch.text_char);
    push_item.char_present = in_ch.char_present;
    push_item.last         = in_ch.last;
  end

endmodule

// File: src/ftms_queue.sv
// two-entry queue between the front and the scoring back end
module ftms_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ftms_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output ftms_pkg::item_t  head,
  output logic             head_valid
);

  ftms_pkg::item_t slot_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != 2'd2)
    else $error("push into full queue");

endmodule

// File: src/ftms_back.sv
// scoring back end: running match state per text and the result register
module ftms_back #(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 16,
  parameter int IDX_W         = 4,
  parameter int PL_W          = 5
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ftms_pkg::item_t                       head,
  input  logic                                  head_valid,
  output logic                                  pop,
  input  logic [PL_W-1:0]                       plen,
  input  ftms_pkg::char_t [PATTERN_MAX-1:0]     pat_chars,
  ftms_out_if.source                            out_ch
);

  localparam int SUBS_W = 16;
  localparam int PW1    = POSITION_BITS + 1;
  localparam int SC_W   = 32;

  localparam logic [SUBS_W-1:0] PTS_CHAR     = 16'd10;
  localparam logic [SUBS_W-1:0] PTS_BOUNDARY = 16'd25;
  localparam logic [SC_W-1:0]   BASE_PREFIX  = 32'd1000;
  localparam logic [SC_W-1:0]   BASE_SUBSTR  = 32'd500;
  localparam logic [SC_W-1:0]   NO_MATCH     = '1;

  localparam ftms_pkg::char_t CH_SPACE = 8'h20;
  localparam ftms_pkg::char_t CH_SLASH = 8'h2f;
  localparam ftms_pkg::char_t CH_DOT   = 8'h2e;
  localparam ftms_pkg::char_t CH_DASH  = 8'h2d;
  localparam ftms_pkg::char_t CH_UNDER = 8'h5f;

  function automatic logic is_boundary(input ftms_pkg::char_t ch);
    return (ch == CH_SPACE) || (ch == CH_SLASH) || (ch == CH_DOT) ||
           (ch == CH_DASH) || (ch == CH_UNDER);
  endfunction

  // running text state
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     sat_r, sat_nxt;
  logic                     occ_found_r, occ_found_nxt;
  logic [POSITION_BITS-1:0] occ_pos_r, occ_pos_nxt;
  logic [PL_W-1:0]          pidx_r, pidx_nxt;
  logic [IDX_W-1:0]         run_r, run_nxt;
  logic [SUBS_W-1:0]        subs_r, subs_nxt;
  logic                     prev_matched_r, prev_matched_nxt;
  ftms_pkg::char_t          prev_char_r, prev_char_nxt;
  logic [PATTERN_MAX-1:0]   mvec_r, mvec_nxt;

  // result register
  logic                        out_valid_r;
  logic [ftms_pkg::SCORE_W-1:0] out_score_r;
  ftms_pkg::kind_t             out_kind_r;
  logic                        out_sat_r;

  logic [PATTERN_MAX-1:0]      eq;
  logic [PL_W-1:0]             plen_m1;
  logic                        hit;
  logic                        at_max;
  logic                        sub_match;
  logic [IDX_W-1:0]            run_inc;
  logic [PW1-1:0]              occ_calc;
  logic [SC_W-1:0]             sc;
  ftms_pkg::kind_t             kd;

  assign pop = head_valid && (!head.last || !out_valid_r || out_ch.ready);

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      eq[k] = (head.text_char == pat_chars[k]);
    end
  end

  // next state when the head word is taken
  always_comb begin
    pos_nxt          = pos_r;
    sat_nxt          = sat_r;
    occ_found_nxt    = occ_found_r;
    occ_pos_nxt      = occ_pos_r;
    pidx_nxt         = pidx_r;
    run_nxt          = run_r;
    subs_nxt         = subs_r;
    prev_matched_nxt = prev_matched_r;
    prev_char_nxt    = prev_char_r;
    mvec_nxt         = mvec_r;
    at_max           = &pos_r;
    plen_m1          = plen - 1'b1;
    hit              = 1'b0;
    sub_match        = 1'b0;
    run_inc          = run_r + 1'b1;
    occ_calc         = PW1'(pos_r) + 1'b1 - PW1'(plen);

    if (head.char_present) begin
      if (at_max) begin
        sat_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end

      // bit k: the last k+1 characters equal pattern characters 0..k
      mvec_nxt[0] = eq[0];
      for (int k = 1; k < PATTERN_MAX; k++) begin
        mvec_nxt[k] = mvec_r[k-1] && eq[k];
      end

      hit = (plen != '0) && mvec_nxt[plen_m1[IDX_W-1:0]];
      if (!occ_found_r && hit) begin
        occ_found_nxt = 1'b1;
        occ_pos_nxt   = occ_calc[POSITION_BITS-1:0];
      end

      // greedy subsequence
      sub_match = (pidx_r < plen) && eq[pidx_r[IDX_W-1:0]];
      if (sub_match) begin
        subs_nxt = subs_r + PTS_CHAR;
        if (prev_matched_r) begin
          run_nxt  = run_inc;
          subs_nxt = subs_nxt + (SUBS_W'(run_inc) << 4) - SUBS_W'(run_inc);
        end else begin
          run_nxt = '0;
        end
        if ((pos_r == '0) || is_boundary(prev_char_r)) begin
          subs_nxt = subs_nxt + PTS_BOUNDARY;
        end
        pidx_nxt = pidx_r + 1'b1;
      end
      prev_matched_nxt = sub_match;
      prev_char_nxt    = head.text_char;
    end
  end

  // score from the state after the final word
  always_comb begin
    sc = NO_MATCH;
    kd = ftms_pkg::KIND_NONE;
    if (plen == '0) begin
      sc = '0;
      kd = ftms_pkg::KIND_EMPTY;
    end else if (pos_nxt == '0) begin
      sc = NO_MATCH;
      kd = ftms_pkg::KIND_NONE;
    end else if (occ_found_nxt && (occ_pos_nxt == '0)) begin
      sc = BASE_PREFIX + SC_W'(plen) - SC_W'(pos_nxt);
      kd = ftms_pkg::KIND_PREFIX;
    end else if (occ_found_nxt) begin
      sc = BASE_SUBSTR - ((SC_W'(occ_pos_nxt) << 3) + (SC_W'(occ_pos_nxt) << 1));
      kd = ftms_pkg::KIND_SUBSTR;
    end else if (pidx_nxt == plen) begin
      sc = SC_W'(subs_nxt);
      kd = ftms_pkg::KIND_SUBSEQ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (pop && head.last)) begin
      pos_r          <= '0;
      sat_r          <= 1'b0;
      occ_found_r    <= 1'b0;
      occ_pos_r      <= '0;
      pidx_r         <= '0;
      run_r          <= '0;
      subs_r         <= '0;
      prev_matched_r <= 1'b0;
      prev_char_r    <= '0;
      mvec_r         <= '0;
    end else if (pop) begin
      pos_r          <= pos_nxt;
      sat_r          <= sat_nxt;
      occ_found_r    <= occ_found_nxt;
      occ_pos_r      <= occ_pos_nxt;
      pidx_r         <= pidx_nxt;
      run_r          <= run_nxt;
      subs_r         <= subs_nxt;
      prev_matched_r <= prev_matched_nxt;
      prev_char_r    <= prev_char_nxt;
      mvec_r         <= mvec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_score_r <= sc[ftms_pkg::SCORE_W-1:0];
      out_kind_r  <= kd;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.score            = out_score_r;
  assign out_ch.match_kind       = out_kind_r;
  assign out_ch.length_saturated = out_sat_r;

  a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (&pos_r))
    else $error("saturation flag without full position counter");

  a_occ_behind_pos: assert property (@(posedge clk) disable iff (!rst_n)
    occ_found_r |-> (occ_pos_r <= pos_r))
    else $error("occurrence start beyond text position");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    PL_W'(run_r) <= pidx_r)
    else $error("run length exceeds matched pattern characters");

endmodule

// File: src/fuzzy_text_match_scorer_top.sv
// top level of the fuzzy text match scorer: config registers, front, queue, back
// a final word's score reaches out_ch through a queue slot and then the result register
// throughput: one text word per cycle while out_ch is not stalled, set by the state update
// in the back end; the two-entry queue and the output register let both sides stall
// reset (synchronous, rst_n low) clears the pattern registers to zero, the queue,
// the running text state and the output valid flag; no clearing pass is needed
module fuzzy_text_match_scorer_top #(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ftms_in_if.sink                           in_ch,
  ftms_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ftms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftms_pkg::CFG_W-1:0]        cfg_wdata
);

  // width of a pattern index and of a clamped pattern length
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int PL_W  = $clog2(PATTERN_MAX + 1);

  logic [ftms_pkg::CFG_LEN_W-1:0] len_r;
  logic [ftms_pkg::CFG_W-1:0]     word_r [ftms_pkg::WORD_CNT];

  logic [PL_W-1:0]                        plen;
  ftms_pkg::char_t [PATTERN_MAX-1:0]      pat_chars;

  logic             q_full;
  logic             q_push;
  ftms_pkg::item_t  q_push_item;
  logic             q_pop;
  ftms_pkg::item_t  q_head;
  logic             q_head_valid;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      for (int w = 0; w < ftms_pkg::WORD_CNT; w++) begin
        word_r[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        ftms_pkg::REG_PATTERN_LENGTH: len_r     <= cfg_wdata[ftms_pkg::CFG_LEN_W-1:0];
        ftms_pkg::REG_PATTERN_WORD0:  word_r[0] <= cfg_wdata;
        ftms_pkg::REG_PATTERN_WORD1:  word_r[1] <= cfg_wdata;
        ftms_pkg::REG_PATTERN_WORD2:  word_r[2] <= cfg_wdata;
        ftms_pkg::REG_PATTERN_WORD3:  word_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // lengths past the pattern store clamp to its size
  assign plen = (32'(len_r) > 32'(PATTERN_MAX)) ? PL_W'(PATTERN_MAX) : PL_W'(len_r);

  // folded pattern characters; positions past the four words read as zero
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
    if (k < ftms_pkg::CFG_CHARS) begin : g_cfg
      assign pat_chars[k] = ftms_pkg::fold(word_r[k / 4][(k % 4) * 8 +: 8]);
    end else begin : g_zero
      assign pat_chars[k] = '0;
    end
  end

  ftms_front u_front (
    .in_ch     (in_ch),
    .full      (q_full),
    .push      (q_push),
    .push_item (q_push_item)
  );

  ftms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  ftms_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS),
    .IDX_W         (IDX_W),
    .PL_W          (PL_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .plen       (plen),
    .pat_chars  (pat_chars),
    .out_ch     (out_ch)
  );

endmodule

// File: tb/fuzzy_text_match_scorer_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the fuzzy text match scorer top level
module fuzzy_text_match_scorer_top_tb;

  localparam int PAT_SLOTS   = 16;
  localparam int POS_TOP     = 65535;  // text position counter saturates here
  localparam int HALF_PERIOD = 4;
  localparam int IDX_W       = ftms_pkg::CFG_IDX_W;
  localparam int DATA_W      = ftms_pkg::CFG_W;

  // one expected score word
  typedef struct {
    logic signed [ftms_pkg::SCORE_W-1:0] score;
    ftms_pkg::kind_t                     kind;
    logic                                sat;
  } score_rec_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_wdata;

  ftms_in_if  in_ch ();
  ftms_out_if out_ch ();

  fuzzy_text_match_scorer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // mirror of the pattern registers, updated as they are written
  logic [ftms_pkg::CFG_LEN_W-1:0] cfg_len = '0;
  logic [DATA_W-1:0]              cfg_word [ftms_pkg::WORD_CNT] = '{default: '0};

  // running text state of the score predictor
  ftms_pkg::char_t recent [PAT_SLOTS];
  int unsigned     text_pos;
  bit              len_sat;
  bit              occ_found;
  int unsigned     occ_pos;
  int unsigned     seq_idx;
  int unsigned     run_len;
  int unsigned     seq_score;
  bit              prev_hit;
  ftms_pkg::char_t prev_ch;

  score_rec_t pending_scores [$];
  score_rec_t want;
  int         mismatch_count = 0;

  // stimulus control shared with the sink process
  bit              src_idle = 1'b1;
  bit              sink_idle = 1'b1;
  int              hold_cycles = 0;
  int              words_sent = 0;
  ftms_pkg::char_t pat_raw [PAT_SLOTS];
  ftms_pkg::char_t txt [$];
  ftms_pkg::char_t seps [5] = '{8'h20, 8'h2f, 8'h2e, 8'h2d, 8'h5f};

  // ---------------------------------------------------------------- predictor

  function automatic ftms_pkg::char_t lower_of(input ftms_pkg::char_t c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic ftms_pkg::char_t pattern_char(input int unsigned k);
    logic [DATA_W-1:0] w;
    w = cfg_word[k / 4] >> (8 * (k % 4));
    return lower_of(w[7:0]);
  endfunction

  function automatic bit is_separator(input ftms_pkg::char_t c);
    return c == 8'h20 || c == 8'h2f || c == 8'h2e || c == 8'h2d || c == 8'h5f;
  endfunction

  function automatic void clear_text_state();
    recent    = '{default: '0};
    text_pos  = 0;
    len_sat   = 1'b0;
    occ_found = 1'b0;
    occ_pos   = 0;
    seq_idx   = 0;
    run_len   = 0;
    seq_score = 0;
    prev_hit  = 1'b0;
    prev_ch   = '0;
  endfunction

  // advance the text state by one accepted word, queue a score on the final one
  function automatic void score_text_word(input ftms_pkg::char_t raw, input bit present,
                                          input bit last_w);
    ftms_pkg::char_t c;
    int unsigned     eff, pos, k;
    bit              same, hit;
    longint          sc;
    score_rec_t      rec;
    c   = lower_of(raw);
    eff = (cfg_len > PAT_SLOTS) ? PAT_SLOTS : cfg_len;
    if (present) begin
      pos = text_pos;
      if (text_pos >= POS_TOP) begin
        len_sat = 1'b1;
      end else begin
        text_pos++;
      end
      for (k = PAT_SLOTS - 1; k > 0; k--) begin
        recent[k] = recent[k - 1];
      end
      recent[0] = c;
      // first window that equals the whole pattern
      if (!occ_found && eff > 0 && pos + 1 >= eff) begin
        same = 1'b1;
        for (k = 0; k < eff; k++) begin
          if (recent[eff - 1 - k] != pattern_char(k)) same = 1'b0;
        end
        if (same) begin
          occ_found = 1'b1;
          occ_pos   = pos + 1 - eff;
        end
      end
      // greedy subsequence with run and word-start bonuses
      hit = 1'b0;
      if (seq_idx < eff && c == pattern_char(seq_idx)) begin
        hit = 1'b1;
        seq_score += 10;
        if (prev_hit) begin
          run_len++;
          seq_score += 15 * run_len;
        end else begin
          run_len = 0;
        end
        if (pos == 0 || is_separator(prev_ch)) seq_score += 25;
        seq_idx++;
      end
      prev_hit = hit;
      prev_ch  = c;
    end
    if (!last_w) return;
    rec.sat = len_sat;
    if (eff == 0) begin
      sc = 0;
      rec.kind = ftms_pkg::KIND_EMPTY;
    end else if (text_pos == 0) begin
      sc = -1;
      rec.kind = ftms_pkg::KIND_NONE;
    end else if (occ_found && occ_pos == 0) begin
      sc = 1000 - (longint'(text_pos) - longint'(eff));
      rec.kind = ftms_pkg::KIND_PREFIX;
    end else if (occ_found) begin
      sc = 500 - 10 * longint'(occ_pos);
      rec.kind = ftms_pkg::KIND_SUBSTR;
    end else if (seq_idx == eff) begin
      sc = seq_score;
      rec.kind = ftms_pkg::KIND_SUBSEQ;
    end else begin
      sc = -1;
      rec.kind = ftms_pkg::KIND_NONE;
    end
    rec.score = sc[ftms_pkg::SCORE_W-1:0];
    pending_scores = {pending_scores, rec};
    clear_text_state();
  endfunction

  // every accepted text word goes through the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      score_text_word(in_ch.text_char, in_ch.char_present, in_ch.last);
    end
  end

  // ------------------------------------------------------------------ checker

  function automatic void report_mismatch(input string field, input longint exp_v,
                                          input longint got_v);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_scores.size() == 0) begin
        mismatch_count++;
        $display("%0t: score word with nothing expected, expected none, actual %0d",
                 $time, out_ch.score);
      end else begin
        want = pending_scores.pop_front();
        if (out_ch.score !== want.score) report_mismatch("score", want.score, out_ch.score);
        if (out_ch.match_kind !== want.kind) begin
          report_mismatch("match_kind", want.kind, out_ch.match_kind);
        end
        if (out_ch.length_saturated !== want.sat) begin
          report_mismatch("length_saturated", want.sat, out_ch.length_saturated);
        end
      end
    end
  end

  // ------------------------------------------------------------ score sink
  // random stalls per word; a requested hold keeps ready low for a long stretch
  initial begin : score_sink
    int n;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = sink_idle ? $urandom_range(0, 6) : 0;
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // ------------------------------------------------------------ drive tasks

  // offer one text word, after a random gap when src_idle is set, return once it is taken
  task automatic send_word(input ftms_pkg::char_t ch, input bit present, input bit last_w);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.text_char    <= ch;
    in_ch.char_present <= present;
    in_ch.last         <= last_w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_literal(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_word(ftms_pkg::char_t'(s[i]), 1'b1, i == s.len() - 1);
    end
  endtask

  // stop offering and wait until every expected score is back, then let the
  // pipeline settle so register writes land on an idle block
  task automatic drain_scores();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      ftms_pkg::REG_PATTERN_LENGTH: cfg_len = val[ftms_pkg::CFG_LEN_W-1:0];
      ftms_pkg::REG_PATTERN_WORD0, ftms_pkg::REG_PATTERN_WORD1,
      ftms_pkg::REG_PATTERN_WORD2, ftms_pkg::REG_PATTERN_WORD3: begin
        cfg_word[idx - ftms_pkg::REG_PATTERN_WORD0] = val;
      end
      default: ;  // unmapped index, no effect
    endcase
  endtask

  // write pat_raw into the four words and then the length, now and then
  // poking an unmapped index as well
  task automatic program_pattern(input int pat_len);
    int k;
    if ($urandom_range(0, 4) == 0) begin
      cfg_write(IDX_W'($urandom_range(int'(ftms_pkg::REG_PATTERN_WORD3) + 1,
                                      (1 << IDX_W) - 1)), $urandom());
    end
    for (k = 0; k < ftms_pkg::WORD_CNT; k++) begin
      cfg_write(IDX_W'(int'(ftms_pkg::REG_PATTERN_WORD0) + k),
                {pat_raw[4*k+3], pat_raw[4*k+2], pat_raw[4*k+1], pat_raw[4*k]});
    end
    cfg_write(ftms_pkg::REG_PATTERN_LENGTH, DATA_W'(pat_len));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pattern_str(input string s, input int pat_len);
    int k;
    for (k = 0; k < PAT_SLOTS; k++) begin
      pat_raw[k] = (k < s.len()) ? ftms_pkg::char_t'(s[k]) : 8'h00;
    end
    program_pattern(pat_len);
  endtask

  // ------------------------------------------------------------ random text

  function automatic void append_char(input ftms_pkg::char_t c);
    txt = {txt, c};
  endfunction

  function automatic ftms_pkg::char_t flip_case(input ftms_pkg::char_t c);
    if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) == 1) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // mostly a few letters and separators so that matches are common
  function automatic ftms_pkg::char_t noise_char();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return flip_case(ftms_pkg::char_t'(8'h61 + $urandom_range(0, 3)));
    if (r < 12) return seps[$urandom_range(0, 4)];
    return ftms_pkg::char_t'($urandom_range(0, 255));
  endfunction

  function automatic ftms_pkg::char_t pat_text(input int unsigned k);
    return flip_case(lower_of(pat_raw[k]));
  endfunction

  // text shapes: prefix, inner occurrence, spread subsequence, noise,
  // empty, and a pattern with one character broken
  function automatic void build_text(input int unsigned eff);
    int unsigned form, k, bad;
    txt.delete();
    form = (eff == 0) ? 7 : $urandom_range(0, 9);
    case (form)
      0, 1: begin
        for (k = 0; k < eff; k++) append_char(pat_text(k));
        repeat ($urandom_range(0, 4)) append_char(noise_char());
      end
      2, 3: begin
        repeat ($urandom_range(1, 5)) append_char(noise_char());
        for (k = 0; k < eff; k++) append_char(pat_text(k));
        repeat ($urandom_range(0, 3)) append_char(noise_char());
      end
      4, 5, 6: begin
        for (k = 0; k < eff; k++) begin
          repeat ($urandom_range(0, 2)) append_char(noise_char());
          append_char(pat_text(k));
        end
        repeat ($urandom_range(0, 2)) append_char(noise_char());
      end
      7: begin
        repeat ($urandom_range(1, 12)) append_char(noise_char());
      end
      8: ;  // empty text
      default: begin
        bad = $urandom_range(0, eff - 1);
        repeat ($urandom_range(0, 2)) append_char(noise_char());
        for (k = 0; k < eff; k++) begin
          append_char((k == bad) ? noise_char() : pat_text(k));
        end
      end
    endcase
  endfunction

  // send txt, sometimes with ignored words inside and sometimes closed
  // by an absent word carrying last
  task automatic send_text();
    int  i;
    bit  absent_close;
    absent_close = (txt.size() == 0) || ($urandom_range(0, 9) == 0);
    for (i = 0; i < txt.size(); i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_word(ftms_pkg::char_t'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_word(txt[i], 1'b1, !absent_close && (i == txt.size() - 1));
      words_sent++;
    end
    if (absent_close) begin
      send_word(ftms_pkg::char_t'($urandom_range(0, 255)), 1'b0, 1'b1);
      words_sent++;
    end
  endtask

  task automatic choose_pattern();
    int r, k, pat_len;
    r = $urandom_range(0, 19);
    if (r == 0) pat_len = 0;
    else if (r == 1) pat_len = $urandom_range(17, 31);
    else if (r < 5) pat_len = $urandom_range(9, 16);
    else pat_len = $urandom_range(1, 8);
    for (k = 0; k < PAT_SLOTS; k++) pat_raw[k] = noise_char();
    program_pattern(pat_len);
  endtask

  // ------------------------------------------------------------ tests

  // nothing configured yet: any text, even an empty one, scores as empty pattern
  task automatic test_empty_pattern();
    send_literal("a");
    send_word(8'h00, 1'b0, 1'b1);
    drain_scores();
  endtask

  // empty text, and an absent word without last that must be ignored
  task automatic test_empty_text();
    set_pattern_str("Ab", 2);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h61, 1'b0, 1'b0);
    send_literal("aB");
    drain_scores();
  endtask

  // prefix, inner occurrence, subsequence with bonuses, no match
  task automatic test_match_rules();
    set_pattern_str("AbC", 3);
    send_literal("abcd");
    send_literal("xABC");
    send_literal("a-b_c");
    send_literal("x/a.bc");
    send_literal("ax");
    drain_scores();
  endtask

  // byte extremes, fold edges, clamped length and unmapped indexes
  task automatic test_extremes();
    int k;
    for (k = 0; k < PAT_SLOTS; k++) pat_raw[k] = 8'hff;
    program_pattern(31);
    for (k = 0; k < PAT_SLOTS; k++) send_word(8'hff, 1'b1, k == PAT_SLOTS - 1);
    drain_scores();
    for (k = int'(ftms_pkg::REG_PATTERN_WORD3) + 1; k < (1 << IDX_W); k++) begin
      cfg_write(IDX_W'(k), '1);
    end
    set_pattern_str("@AZ[", 4);
    send_literal("@az[");
    send_literal("`AZ{");
    drain_scores();
    set_pattern_str("", 2);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    drain_scores();
  endtask

  // receiver holds off while the sender streams short texts back to back
  task automatic test_backpressure();
    set_pattern_str("ab", 2);
    src_idle = 1'b0;
    hold_cycles = 80;
    repeat (30) send_literal("ab");
    drain_scores();  // sender waits here until every score is back
    src_idle = 1'b1;
  endtask

  // random patterns and texts, new pattern and idle mix every few texts
  task automatic test_random();
    int texts;
    texts = 0;
    words_sent = 0;
    while (words_sent < 780) begin
      if (texts % 6 == 0) begin
        drain_scores();
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        choose_pattern();
      end
      build_text((cfg_len > PAT_SLOTS) ? PAT_SLOTS : cfg_len);
      send_text();
      texts++;
    end
    drain_scores();
  endtask

  // ------------------------------------------------------------ sequence

  initial begin : main_seq
    int guard;
    in_ch.valid        = 1'b0;
    in_ch.text_char    = '0;
    in_ch.char_present = 1'b0;
    in_ch.last         = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    clear_text_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pattern();
    test_empty_text();
    test_match_rules();
    test_extremes();
    test_backpressure();
    test_random();

    in_ch.valid <= 1'b0;
    for (guard = 0; guard < 5000 && pending_scores.size() != 0; guard++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_scores.size() != 0) begin
      mismatch_count++;
      $display("%0t: missing score words, expected %0d more, actual 0",
               $time, pending_scores.size());
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : run_limit
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
